// ===== rtl/hht_pkg.sv =====
package hht_pkg;

    localparam int TABLE_SIZE   = 32;   // power of two: home slot is the low bits
    localparam int PROBE_STRIDE = 7;
    localparam int HANDLE_BITS  = 15;

    localparam int FUNC_W   = 1;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = $clog2(TABLE_SIZE);
    localparam int COUNT_W  = $clog2(TABLE_SIZE + 1);

    localparam int STRIDE_MOD = PROBE_STRIDE % TABLE_SIZE;

    localparam logic [FUNC_W-1:0] FN_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE = 2'd0,
        STAT_NEG  = 2'd1,
        STAT_FAIL = 2'd2
    } t_status;

endpackage

// ===== rtl/hht_ram.sv =====
module hht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/handle_hash_table.sv =====
// channel   direction  handshake           word
// request   in         i_valid / o_ready   i_func, i_handle
// response  out        o_valid / i_ready   o_status, o_slot, o_live_count
//
// One request at a time; a new one is taken while the last response waits.
// Steps: accept, sign check, probe each slot in turn (none for a negative handle,
// up to TABLE_SIZE slots), commit or report, then load the response.
// The probe loop is one microprogram step per slot, paced by the RAM's registered read.
// Reset empties every slot and zeroes the live count at once.
// A stalled response holds the sequencer in its load step.
module handle_hash_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hht_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [hht_pkg::HANDLE_W-1:0] i_handle,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hht_pkg::STATUS_W-1:0]        o_status,
    output logic [hht_pkg::SLOT_W-1:0]          o_slot,
    output logic [hht_pkg::COUNT_W-1:0]         o_live_count
);

    localparam int SW = hht_pkg::SLOT_W;
    localparam int CW = hht_pkg::COUNT_W;
    localparam int KW = hht_pkg::HANDLE_BITS;

    typedef enum logic [2:0] {
        SQ_WAIT, SQ_NEG, SQ_PROBE, SQ_HIT, SQ_MISS, SQ_REJ, SQ_EMIT
    } t_step;

    typedef enum logic [2:0] {
        CD_FALSE, CD_TRUE, CD_IN_VALID, CD_NEG, CD_HIT, CD_WRAP, CD_OUT_FREE
    } t_cond;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_STEP, OP_COMMIT, OP_MISS, OP_REJ, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op   op;
        t_cond cond_a;
        t_step tgt_a;
        t_cond cond_b;
        t_step tgt_b;
        t_step tgt_else;
    } t_ctrl;

    function automatic t_ctrl f_rom(input t_step s);
        t_ctrl c;
        c = '{OP_NONE, CD_TRUE, SQ_WAIT, CD_FALSE, SQ_WAIT, SQ_WAIT};
        unique case (s)
            SQ_WAIT:  c = '{OP_LOAD,   CD_IN_VALID, SQ_NEG,  CD_FALSE, SQ_WAIT, SQ_WAIT};
            SQ_NEG:   c = '{OP_NONE,   CD_NEG,      SQ_REJ,  CD_FALSE, SQ_WAIT, SQ_PROBE};
            SQ_PROBE: c = '{OP_STEP,   CD_HIT,      SQ_HIT,  CD_WRAP,  SQ_MISS, SQ_PROBE};
            SQ_HIT:   c = '{OP_COMMIT, CD_TRUE,     SQ_EMIT, CD_FALSE, SQ_WAIT, SQ_EMIT};
            SQ_MISS:  c = '{OP_MISS,   CD_TRUE,     SQ_EMIT, CD_FALSE, SQ_WAIT, SQ_EMIT};
            SQ_REJ:   c = '{OP_REJ,    CD_TRUE,     SQ_EMIT, CD_FALSE, SQ_WAIT, SQ_EMIT};
            SQ_EMIT:  c = '{OP_EMIT,   CD_OUT_FREE, SQ_WAIT, CD_FALSE, SQ_WAIT, SQ_EMIT};
            default:  c = '{OP_NONE,   CD_TRUE,     SQ_WAIT, CD_FALSE, SQ_WAIT, SQ_WAIT};
        endcase
        return c;
    endfunction

    t_step                       r_upc, n_upc;
    logic [hht_pkg::FUNC_W-1:0]  r_func, n_func;
    logic                        r_neg, n_neg;
    logic [KW-1:0]               r_key, n_key;
    logic [SW-1:0]               r_home, n_home;
    logic [SW-1:0]               r_pos, n_pos;
    logic [hht_pkg::TABLE_SIZE-1:0] r_used, n_used;
    logic [CW-1:0]               r_count, n_count;
    hht_pkg::t_status            r_res_status, n_res_status;
    logic [SW-1:0]               r_res_slot, n_res_slot;
    logic                        r_out_valid, n_out_valid;
    hht_pkg::t_status            r_out_status, n_out_status;
    logic [SW-1:0]               r_out_slot, n_out_slot;
    logic [CW-1:0]               r_out_count, n_out_count;

    t_ctrl         ctrl;
    logic          accept;
    logic          hit;
    logic          wrap;
    logic          out_free;
    logic          cond_a_true;
    logic          cond_b_true;
    logic [SW:0]   pos_sum;
    logic [SW-1:0] pos_next;
    logic [KW-1:0] rd_key;
    logic          ram_we;

    function automatic logic f_eval(input t_cond c, input logic in_v, input logic neg,
                                    input logic h, input logic w, input logic of);
        logic r;
        r = 1'b0;
        unique case (c)
            CD_FALSE:    r = 1'b0;
            CD_TRUE:     r = 1'b1;
            CD_IN_VALID: r = in_v;
            CD_NEG:      r = neg;
            CD_HIT:      r = h;
            CD_WRAP:     r = w;
            CD_OUT_FREE: r = of;
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    assign ctrl     = f_rom(r_upc);
    assign o_ready  = (ctrl.op == OP_LOAD);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign pos_sum  = {1'b0, r_pos} + (SW + 1)'(hht_pkg::STRIDE_MOD);
    assign pos_next = (pos_sum >= (SW + 1)'(hht_pkg::TABLE_SIZE))
                    ? SW'(pos_sum - (SW + 1)'(hht_pkg::TABLE_SIZE))
                    : pos_sum[SW-1:0];
    assign wrap     = (pos_next == r_home);
    assign hit      = (r_func == hht_pkg::FN_INSERT) ? !r_used[r_pos]
                    : (r_used[r_pos] && (rd_key == r_key));

    assign cond_a_true = f_eval(ctrl.cond_a, i_valid, r_neg, hit, wrap, out_free);
    assign cond_b_true = f_eval(ctrl.cond_b, i_valid, r_neg, hit, wrap, out_free);

    assign ram_we = (ctrl.op == OP_COMMIT) && (r_func == hht_pkg::FN_INSERT);

    always_comb begin
        n_upc        = cond_a_true ? ctrl.tgt_a : (cond_b_true ? ctrl.tgt_b : ctrl.tgt_else);
        n_func       = r_func;
        n_neg        = r_neg;
        n_key        = r_key;
        n_home       = r_home;
        n_pos        = r_pos;
        n_used       = r_used;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_count  = r_out_count;
        unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                if (accept) begin
                    n_func = i_func;
                    n_neg  = i_handle[hht_pkg::HANDLE_W-1];
                    n_key  = i_handle[KW-1:0];
                    n_home = i_handle[SW-1:0];
                    n_pos  = i_handle[SW-1:0];
                end
            end
            OP_STEP: begin
                if (!hit) begin
                    n_pos = pos_next;
                end
            end
            OP_COMMIT: begin
                n_res_status = hht_pkg::STAT_DONE;
                n_res_slot   = r_pos;
                if (r_func == hht_pkg::FN_INSERT) begin
                    n_used[r_pos] = 1'b1;
                    n_count       = r_count + CW'(1);
                end else begin
                    n_used[r_pos] = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            OP_MISS: begin
                n_res_status = hht_pkg::STAT_FAIL;
                n_res_slot   = '0;
            end
            OP_REJ: begin
                n_res_status = hht_pkg::STAT_NEG;
                n_res_slot   = '0;
            end
            OP_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_count  = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= SQ_WAIT;
            r_used      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_used      <= n_used;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_func       <= n_func;
        r_neg        <= n_neg;
        r_key        <= n_key;
        r_home       <= n_home;
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_count  <= n_out_count;
    end

    // read address follows the next probe position, so data lines up with r_pos
    hht_ram #(
        .WIDTH (KW),
        .DEPTH (hht_pkg::TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_key),
        .i_raddr (n_pos),
        .o_rdata (rd_key)
    );

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot       = r_out_slot;
    assign o_live_count = r_out_count;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_used)))
        else $error("live count out of step with used bits");

    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == SQ_HIT && r_func == hht_pkg::FN_INSERT) |-> !r_used[r_pos])
        else $error("insert into occupied slot");

    a_no_commit_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == SQ_HIT) |-> !r_neg)
        else $error("commit for negative handle");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_upc == SQ_NEG))
        else $error("sequencer skipped sign check");

endmodule

// ===== sim/tb_handle_hash_table.sv =====
`timescale 1ns / 100ps

module tb_handle_hash_table;

    typedef struct packed {
        hht_pkg::t_status                 status;
        logic [hht_pkg::SLOT_W-1:0]       slot;
        logic [hht_pkg::COUNT_W-1:0]      live;
    } t_reply;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic [hht_pkg::FUNC_W-1:0]          i_func = hht_pkg::FN_INSERT;
    logic signed [hht_pkg::HANDLE_W-1:0] i_handle = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [hht_pkg::STATUS_W-1:0]        o_status;
    logic [hht_pkg::SLOT_W-1:0]          o_slot;
    logic [hht_pkg::COUNT_W-1:0]         o_live_count;

    handle_hash_table u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_handle     (i_handle),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_live_count (o_live_count)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the handle table
    logic                            slot_used [hht_pkg::TABLE_SIZE];
    logic [hht_pkg::HANDLE_BITS-1:0] slot_key  [hht_pkg::TABLE_SIZE];
    int                              occupancy;
    int                              peak_occupancy;

    t_reply owed_replies [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int n_errors;
    int n_sent;
    int n_done;
    int n_neg;
    int n_fail;

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic t_reply table_request(logic [hht_pkg::FUNC_W-1:0] f,
                                             logic signed [hht_pkg::HANDLE_W-1:0] h);
        t_reply r;
        int     pos;
        int     hit;
        r.status = hht_pkg::STAT_DONE;
        r.slot   = '0;
        hit      = -1;
        if (h[hht_pkg::HANDLE_W-1]) begin
            r.status = hht_pkg::STAT_NEG;
        end else begin
            pos = int'(h[hht_pkg::HANDLE_W-2:0]) % hht_pkg::TABLE_SIZE;
            for (int n = 0; n < hht_pkg::TABLE_SIZE && hit < 0; n++) begin
                if ((f == hht_pkg::FN_INSERT) ? !slot_used[pos]
                        : (slot_used[pos]
                           && slot_key[pos] == h[hht_pkg::HANDLE_BITS-1:0])) begin
                    hit = pos;
                end else begin
                    pos = (pos + hht_pkg::PROBE_STRIDE) % hht_pkg::TABLE_SIZE;
                end
            end
            if (hit < 0) begin
                r.status = hht_pkg::STAT_FAIL;
            end else if (f == hht_pkg::FN_INSERT) begin
                slot_used[hit] = 1'b1;
                slot_key[hit]  = h[hht_pkg::HANDLE_BITS-1:0];
                occupancy++;
                r.slot = hit[hht_pkg::SLOT_W-1:0];
            end else begin
                slot_used[hit] = 1'b0;
                if (occupancy > 0) occupancy--;
                r.slot = hit[hht_pkg::SLOT_W-1:0];
            end
        end
        if (occupancy > peak_occupancy) peak_occupancy = occupancy;
        r.live = occupancy[hht_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // biased towards a few home slots so probe chains grow long
    function automatic logic signed [hht_pkg::HANDLE_W-1:0] any_handle();
        logic [hht_pkg::HANDLE_W-2:0] v;
        v = (hht_pkg::HANDLE_W - 1)'($urandom);
        case ($urandom_range(0, 9))
            0:          return {1'b1, v};
            1, 2, 3, 4: return {1'b0, 7'd0, v[2:0], 3'd0, v[4:3]};
            default:    return {1'b0, v};
        endcase
    endfunction

    function automatic bit stored_handle(output logic signed [hht_pkg::HANDLE_W-1:0] h);
        int start;
        int idx;
        start = $urandom_range(0, hht_pkg::TABLE_SIZE - 1);
        h = '0;
        for (int k = 0; k < hht_pkg::TABLE_SIZE; k++) begin
            idx = (start + k) % hht_pkg::TABLE_SIZE;
            if (slot_used[idx]) begin
                h = {1'b0, slot_key[idx]};
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_word(logic [hht_pkg::FUNC_W-1:0] f,
                             logic signed [hht_pkg::HANDLE_W-1:0] h);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_func   = f;
        i_handle = h;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        owed_replies.push_back(table_request(f, h));
        n_sent++;
    endtask

    task automatic send_random(int insert_pct);
        logic [hht_pkg::FUNC_W-1:0]          f;
        logic signed [hht_pkg::HANDLE_W-1:0] h;
        f = ($urandom_range(0, 99) < insert_pct) ? hht_pkg::FN_INSERT : hht_pkg::FN_REMOVE;
        h = any_handle();
        if ($urandom_range(0, 99) < (f == hht_pkg::FN_REMOVE ? 75 : 15)) begin
            if (!stored_handle(h)) h = any_handle();
        end
        send_word(f, h);
    endtask

    task automatic test_directed();
        send_word(hht_pkg::FN_INSERT, 16'sd0);
        send_word(hht_pkg::FN_INSERT, 16'sd32);        // same home, next on the path
        send_word(hht_pkg::FN_INSERT, 16'sd32767);
        send_word(hht_pkg::FN_INSERT, 16'sd0);         // duplicate is stored again
        send_word(hht_pkg::FN_INSERT, 16'sh8000);
        send_word(hht_pkg::FN_INSERT, -16'sd1);
        send_word(hht_pkg::FN_REMOVE, -16'sd1);
        send_word(hht_pkg::FN_REMOVE, 16'sd64);        // probes past a collision, misses
        send_word(hht_pkg::FN_REMOVE, 16'sd0);
        send_word(hht_pkg::FN_REMOVE, 16'sd0);
        send_word(hht_pkg::FN_REMOVE, 16'sd0);         // nothing left to free
        send_word(hht_pkg::FN_REMOVE, 16'sd32);
        send_word(hht_pkg::FN_REMOVE, 16'sd32767);
        send_word(hht_pkg::FN_INSERT, 16'sh5555);
        send_word(hht_pkg::FN_INSERT, 16'sh2aaa);
        send_word(hht_pkg::FN_REMOVE, 16'sh2aaa);
        send_word(hht_pkg::FN_REMOVE, 16'sh5555);
        send_word(hht_pkg::FN_REMOVE, 16'sd1);         // empty table
    endtask

    task automatic test_fill_drain();
        while (occupancy < hht_pkg::TABLE_SIZE) send_random(90);
        repeat (4) send_word(hht_pkg::FN_INSERT, {1'b0, 15'($urandom)});   // table full
        repeat (2) send_random(0);
        while (occupancy > 0) send_random(10);
        repeat (2) send_random(0);
    endtask

    task automatic test_random_mix(int n_items);
        repeat (n_items) send_random(50);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (2 * (hht_pkg::TABLE_SIZE + 5)) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_reply
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_replies.size() == 0) begin
                $display("%0t: unexpected reply: status %0d slot %0d live %0d",
                         $time, o_status, o_slot, o_live_count);
                n_errors++;
            end else begin
                want = owed_replies.pop_front();
                case (hht_pkg::t_status'(want.status))
                    hht_pkg::STAT_DONE: n_done++;
                    hht_pkg::STAT_NEG:  n_neg++;
                    default:            n_fail++;
                endcase
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_status);
                    n_errors++;
                end
                if (o_slot !== want.slot) begin
                    $display("%0t: slot mismatch: expected %0d, actual %0d",
                             $time, want.slot, o_slot);
                    n_errors++;
                end
                if (o_live_count !== want.live) begin
                    $display("%0t: live count mismatch: expected %0d, actual %0d",
                             $time, want.live, o_live_count);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        for (int k = 0; k < hht_pkg::TABLE_SIZE; k++) begin
            slot_used[k] = 1'b0;
            slot_key[k]  = '0;
        end
        occupancy      = 0;
        peak_occupancy = 0;
        n_errors       = 0;
        n_sent         = 0;
        n_done         = 0;
        n_neg          = 0;
        n_fail         = 0;
        tx_idle_pct    = 6;
        rx_stall_pct   = 86;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct  = (p == 0) ? 6 : (p == 1) ? 86 : 0;
            rx_stall_pct = (p == 0) ? 86 : (p == 1) ? 6 : 0;
            test_fill_drain();
            test_random_mix(480);
        end
        wait_drained();

        $display("Ran %0d requests: %0d placed or freed, %0d negative, %0d full or missing",
                 n_sent, n_done, n_neg, n_fail);
        $display("Table filled and emptied in each idle mode; peak occupancy %0d of %0d",
                 peak_occupancy, hht_pkg::TABLE_SIZE);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
